FILE: sv/irpwc_pkg.sv
// ----------------------------------------------------------------------------
// irpwc_pkg
// Shared types and constants for the IR pulse-width capture block.
// ----------------------------------------------------------------------------
package irpwc_pkg;

    localparam int FRAME_BYTES = 64;

    localparam logic [7:0] START_THRESHOLD_RST = 8'd40;
    localparam logic [7:0] STOP_THRESHOLD_RST  = 8'd100;
    localparam logic [5:0] FRAME_INDEX_START   = 6'd2;
    localparam logic [5:0] FRAME_INDEX_STEP    = 6'd2;
    localparam logic [7:0] RUN_MAX             = 8'hFF;

    typedef enum logic {
        CFG_START_THRESHOLD = 1'b0,
        CFG_STOP_THRESHOLD  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        KIND_PAIR = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] low_count;
        logic [7:0] high_count;
        logic [5:0] byte_count;
    } t_result;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == RUN_MAX) ? v : v + 8'd1;
    endfunction

endpackage

FILE: sv/ir_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_capture
// Measures low/high run lengths of a sampled IR decoder pin and reports
// pulse pairs and the end-of-frame byte count.
// ----------------------------------------------------------------------------
// output: a result is registered into the result queue and shown from its head r_q0
// throughput: one sample per cycle, set by the single-pass run counter update
// a two-entry result queue keeps samples flowing while one result waits,
// the sample side stalls only while two results wait
// reset: synchronous active low, thresholds back to 40 and 100, waiting mode
// ----------------------------------------------------------------------------
module ir_pulse_width_capture
    import irpwc_pkg::*;
#(
    parameter int FRAME_SIZE = FRAME_BYTES
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // sample channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_sample,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [7:0] o_low_count,
    output logic [7:0] o_high_count,
    output logic [5:0] o_byte_count,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_start_thr;
    logic [7:0] r_stop_thr;

    logic       r_receiving, n_receiving;
    logic [7:0] r_low_run, n_low_run;
    logic [7:0] r_high_run, n_high_run;
    logic       r_sync_wait, n_sync_wait;
    logic       r_prev, n_prev;
    logic [5:0] r_frame_idx, n_frame_idx;

    logic       emit;
    t_result    res;
    logic [7:0] lr_inc;
    logic [7:0] hr_inc;
    logic [6:0] idx_next;

    t_result    r_q0, r_q1;
    logic [1:0] r_cnt;

    logic       in_acc;
    logic       push;
    logic       pop;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_cnt != 2'd2);
    assign in_acc      = i_valid && o_ready;
    assign push        = in_acc && emit;
    assign pop         = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr <= START_THRESHOLD_RST;
            r_stop_thr  <= STOP_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_THRESHOLD: r_start_thr <= i_cfg_data;
                CFG_STOP_THRESHOLD:  r_stop_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_receiving = r_receiving;
        n_low_run   = r_low_run;
        n_high_run  = r_high_run;
        n_sync_wait = r_sync_wait;
        n_prev      = i_sample;
        n_frame_idx = r_frame_idx;
        emit        = 1'b0;
        res         = '{kind: KIND_PAIR, low_count: '0, high_count: '0, byte_count: '0};
        lr_inc      = sat_inc(r_low_run);
        hr_inc      = sat_inc(r_high_run);
        idx_next    = {1'b0, r_frame_idx} + {1'b0, FRAME_INDEX_STEP};

        if (!r_receiving) begin
            if (!i_sample) begin
                if (lr_inc >= r_start_thr) begin
                    n_receiving = 1'b1;
                    n_sync_wait = 1'b1;
                    n_low_run   = '0;
                    n_high_run  = '0;
                    n_frame_idx = FRAME_INDEX_START;
                end else begin
                    n_low_run = lr_inc;
                end
            end else begin
                n_low_run = '0;
            end
        end else if (i_sample == r_prev) begin
            if (!r_sync_wait) begin
                if (i_sample) begin
                    n_high_run = hr_inc;
                end else begin
                    n_low_run = lr_inc;
                end
                // stop check uses the updated high run
                if (n_high_run >= r_stop_thr) begin
                    n_receiving    = 1'b0;
                    n_low_run      = '0;
                    emit           = 1'b1;
                    res.kind       = KIND_END;
                    res.byte_count = r_frame_idx;
                end
            end
        end else begin
            if (!r_sync_wait) begin
                if (!r_prev) begin
                    // rising edge closes a low/high pair
                    if (idx_next < 7'(FRAME_SIZE)) begin
                        emit           = 1'b1;
                        res.low_count  = r_low_run;
                        res.high_count = r_high_run;
                        n_frame_idx    = idx_next[5:0];
                    end
                    n_low_run  = '0;
                    n_high_run = 8'd1;
                end else begin
                    n_low_run = 8'd1;
                end
            end
            n_sync_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_low_run   <= '0;
            r_high_run  <= '0;
            r_sync_wait <= 1'b0;
            r_prev      <= 1'b0;
            r_frame_idx <= FRAME_INDEX_START;
        end else if (in_acc) begin
            r_receiving <= n_receiving;
            r_low_run   <= n_low_run;
            r_high_run  <= n_high_run;
            r_sync_wait <= n_sync_wait;
            r_prev      <= n_prev;
            r_frame_idx <= n_frame_idx;
        end
    end

    // two-entry result queue, r_q0 is the head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case (r_cnt)
                2'd0: if (push) r_cnt <= 2'd1;
                2'd1: if (push && !pop) r_cnt <= 2'd2;
                      else if (pop && !push) r_cnt <= 2'd0;
                2'd2: if (pop) r_cnt <= 2'd1;
                default: r_cnt <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: if (push) r_q0 <= res;
            2'd1: begin
                if (pop && push) begin
                    r_q0 <= res;
                end else if (push) begin
                    r_q1 <= res;
                end
            end
            2'd2: if (pop) r_q0 <= r_q1;
            default: ;
        endcase
    end

    assign o_valid      = (r_cnt != 2'd0);
    assign o_kind       = r_q0.kind;
    assign o_low_count  = r_q0.low_count;
    assign o_high_count = r_q0.high_count;
    assign o_byte_count = r_q0.byte_count;

endmodule
